FILE: hdl/cts_pkg.sv
// Shared types and constants of the coprocessor task scheduler.
package cts_pkg;

  localparam int MAILBOX_DEPTH = 16;
  localparam int TASK_ID_BITS  = 8;
  localparam int MB_CNT_BITS   = $clog2(MAILBOX_DEPTH + 1);
  localparam int OP_BITS       = 3;
  localparam int LISTENER_BITS = 2;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  typedef logic [TASK_ID_BITS-1:0] task_id_t;

  typedef enum logic [OP_BITS-1:0] {
    OP_MB_SUBMIT   = 3'd0,
    OP_DSP_SUBMIT  = 3'd1,
    OP_VBLANK      = 3'd2,
    OP_COP_DONE    = 3'd3,
    OP_DSP_DONE    = 3'd4,
    OP_START_DSP   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ACT_NONE        = 2'd0,
    ACT_START_AUDIO = 2'd1,
    ACT_START_DSP   = 2'd2,
    ACT_YIELD       = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    KIND_NONE      = 2'd0,
    KIND_AUDIO     = 2'd1,
    KIND_DSP       = 2'd2,
    KIND_DSP_YIELD = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PH_NOT_STARTED = 2'd0,
    PH_RUNNING     = 2'd1,
    PH_INTERRUPTED = 2'd2,
    PH_FINISHED    = 2'd3
  } phase_t;

  typedef struct packed {
    logic     valid;
    task_id_t id;
  } slot_t;

  typedef struct packed {
    action_t                  action;
    task_id_t                 action_task;
    logic                     audio_done;
    logic                     display_done;
    task_id_t                 done_task;
    logic                     start_display_request;
    logic [LISTENER_BITS-1:0] vblank_notify;
    logic                     mailbox_dropped;
  } result_t;

  localparam slot_t SLOT_EMPTY = '{valid: 1'b0, id: '0};

endpackage

FILE: hdl/cts_in_if.sv
// Event channel into the scheduler.
interface cts_in_if import cts_pkg::*; ();
  logic     valid;
  logic     ready;
  logic [OP_BITS-1:0] op;
  task_id_t task_id;
  logic     task_is_audio;
  logic     yielded;

  modport source (output valid, output op, output task_id, output task_is_audio,
                  output yielded, input ready);
  modport sink   (input valid, input op, input task_id, input task_is_audio,
                  input yielded, output ready);
endinterface

FILE: hdl/cts_out_if.sv
// Result channel out of the scheduler.
interface cts_out_if import cts_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  task_id_t                 action_task;
  logic                     audio_done;
  logic                     display_done;
  task_id_t                 done_task;
  logic                     start_display_request;
  logic [LISTENER_BITS-1:0] vblank_notify;
  logic                     mailbox_dropped;

  modport source (output valid, output action, output action_task, output audio_done,
                  output display_done, output done_task, output start_display_request,
                  output vblank_notify, output mailbox_dropped, input ready);
  modport sink   (input valid, input action, input action_task, input audio_done,
                  input display_done, input done_task, input start_display_request,
                  input vblank_notify, input mailbox_dropped, output ready);
endinterface

FILE: hdl/coprocessor_task_scheduler.sv
// Coprocessor task scheduler: audio/display slot state, event decode and result buffer.
//
// Shares one coprocessor between audio and display tasks. Each event on in_ch
// (mailbox submit, direct display submit, vblank, coprocessor complete,
// display complete, start display) gives exactly one item on out_ch with the
// start or yield action, done notifications and status flags.
// The listener mask register sits at byte address 0 of the APB port; the user
// must write it only while no event is in flight; the block does not enforce this.
// An accepted event's result is registered in the output register (or in the skid
// entry while out_ch is stalled). Throughput: one event per cycle while in_ch.ready
// is high; the state update is a single pass of compare-and-select logic from the slot registers.
// Results go to a two-entry buffer (output register plus skid entry): while
// out_ch is stalled one more event is still accepted, then in_ch.ready drops
// until the receiver takes an item.
// Reset (rst_n low, synchronous) empties all slots and the mailbox, clears
// the running task and the listener mask, and drops any buffered result.
module coprocessor_task_scheduler import cts_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  cts_in_if.sink                   in_ch,
  cts_out_if.source                out_ch,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  logic [LISTENER_BITS-1:0] mask_r;

  kind_t                  act_kind_r, act_kind_nxt;
  task_id_t               act_id_r, act_id_nxt;
  slot_t                  aud_cur_r, aud_cur_nxt;
  slot_t                  aud_pend_r, aud_pend_nxt;
  slot_t                  dsp_cur_r, dsp_cur_nxt;
  slot_t                  dsp_pend_r, dsp_pend_nxt;
  slot_t                  mb_aud_r, mb_aud_nxt;
  slot_t                  mb_dsp_r, mb_dsp_nxt;
  phase_t                 dsp_phase_r, dsp_phase_nxt;
  logic [MB_CNT_BITS-1:0] mb_cnt_r, mb_cnt_nxt;

  result_t res;
  result_t out_main_r, out_skid_r;
  logic    out_main_v_r, out_skid_v_r;
  logic    push, pop;

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr[CFG_ADDR_BITS-1] == 1'b0)
                ? {{(CFG_DATA_BITS-LISTENER_BITS){1'b0}}, mask_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (psel && penable && pwrite && pready && !paddr[CFG_ADDR_BITS-1]) begin
      mask_r <= pwdata[LISTENER_BITS-1:0];
    end
  end

  assign in_ch.ready = !out_skid_v_r;
  assign push        = in_ch.valid && in_ch.ready;
  assign pop         = out_main_v_r && out_ch.ready;

  // Event decode and next state
  always_comb begin
    kind_t  kind_prev;
    task_id_t tid;
    kind_prev     = act_kind_r;
    tid           = in_ch.task_id;
    act_kind_nxt  = act_kind_r;
    act_id_nxt    = act_id_r;
    aud_cur_nxt   = aud_cur_r;
    aud_pend_nxt  = aud_pend_r;
    dsp_cur_nxt   = dsp_cur_r;
    dsp_pend_nxt  = dsp_pend_r;
    mb_aud_nxt    = mb_aud_r;
    mb_dsp_nxt    = mb_dsp_r;
    dsp_phase_nxt = dsp_phase_r;
    mb_cnt_nxt    = mb_cnt_r;
    res           = '0;

    unique case (in_ch.op)
      OP_MB_SUBMIT: begin
        if (mb_cnt_r >= MB_CNT_BITS'(MAILBOX_DEPTH)) begin
          res.mailbox_dropped = 1'b1;
        end else begin
          mb_cnt_nxt = mb_cnt_r + MB_CNT_BITS'(1);
          if (in_ch.task_is_audio) begin
            mb_aud_nxt = '{valid: 1'b1, id: tid};
          end else begin
            mb_dsp_nxt = '{valid: 1'b1, id: tid};
          end
        end
      end
      OP_DSP_SUBMIT: begin
        if (!dsp_cur_r.valid) begin
          dsp_cur_nxt   = '{valid: 1'b1, id: tid};
          dsp_phase_nxt = PH_NOT_STARTED;
          dsp_pend_nxt  = SLOT_EMPTY;
          res.start_display_request = 1'b1;
        end else begin
          dsp_pend_nxt = '{valid: 1'b1, id: tid};
        end
      end
      OP_VBLANK: begin
        // promote mailbox, latest of each kind wins
        if (mb_aud_r.valid) aud_pend_nxt = mb_aud_r;
        if (mb_dsp_r.valid) dsp_pend_nxt = mb_dsp_r;
        mb_aud_nxt = SLOT_EMPTY;
        mb_dsp_nxt = SLOT_EMPTY;
        mb_cnt_nxt = '0;
        if (!aud_cur_r.valid && aud_pend_nxt.valid) begin
          aud_cur_nxt  = aud_pend_nxt;
          aud_pend_nxt = SLOT_EMPTY;
        end
        if (!dsp_cur_r.valid && dsp_pend_nxt.valid) begin
          dsp_cur_nxt   = dsp_pend_nxt;
          dsp_pend_nxt  = SLOT_EMPTY;
          dsp_phase_nxt = PH_NOT_STARTED;
        end
        if (aud_cur_nxt.valid) begin
          if (act_kind_r != KIND_NONE) begin
            // audio preempts a running display task
            if (act_kind_r == KIND_DSP || act_kind_r == KIND_DSP_YIELD) begin
              act_kind_nxt = KIND_DSP_YIELD;
              if (dsp_cur_nxt.valid) dsp_phase_nxt = PH_INTERRUPTED;
              res.action      = ACT_YIELD;
              res.action_task = act_id_r;
            end
          end else begin
            act_kind_nxt    = KIND_AUDIO;
            act_id_nxt      = aud_cur_nxt.id;
            res.action      = ACT_START_AUDIO;
            res.action_task = aud_cur_nxt.id;
          end
        end else if (act_kind_r == KIND_NONE && dsp_cur_nxt.valid &&
                     dsp_phase_nxt != PH_FINISHED) begin
          act_kind_nxt    = KIND_DSP;
          act_id_nxt      = dsp_cur_nxt.id;
          dsp_phase_nxt   = PH_RUNNING;
          res.action      = ACT_START_DSP;
          res.action_task = dsp_cur_nxt.id;
        end
        res.vblank_notify = mask_r;
      end
      OP_COP_DONE: begin
        if (kind_prev != KIND_NONE) begin
          act_kind_nxt = KIND_NONE;
          act_id_nxt   = '0;
          if (kind_prev == KIND_DSP_YIELD) begin
            if (!in_ch.yielded && dsp_cur_r.valid) dsp_phase_nxt = PH_FINISHED;
            if (aud_cur_r.valid) begin
              act_kind_nxt    = KIND_AUDIO;
              act_id_nxt      = aud_cur_r.id;
              res.action      = ACT_START_AUDIO;
              res.action_task = aud_cur_r.id;
            end
          end else if (kind_prev == KIND_AUDIO) begin
            if (dsp_cur_r.valid && dsp_phase_r != PH_FINISHED) begin
              act_kind_nxt    = KIND_DSP;
              act_id_nxt      = dsp_cur_r.id;
              dsp_phase_nxt   = PH_RUNNING;
              res.action      = ACT_START_DSP;
              res.action_task = dsp_cur_r.id;
            end
            aud_cur_nxt    = SLOT_EMPTY;
            res.audio_done = 1'b1;
            res.done_task  = act_id_r;
          end else begin
            if (dsp_cur_r.valid) dsp_phase_nxt = PH_FINISHED;
          end
        end
      end
      OP_DSP_DONE: begin
        if (dsp_cur_r.valid) begin
          res.display_done = 1'b1;
          res.done_task    = dsp_cur_r.id;
          dsp_cur_nxt      = SLOT_EMPTY;
          dsp_phase_nxt    = PH_NOT_STARTED;
        end
      end
      OP_START_DSP: begin
        if (act_kind_r == KIND_NONE && dsp_cur_r.valid && dsp_phase_r == PH_NOT_STARTED) begin
          act_kind_nxt    = KIND_DSP;
          act_id_nxt      = dsp_cur_r.id;
          dsp_phase_nxt   = PH_RUNNING;
          res.action      = ACT_START_DSP;
          res.action_task = dsp_cur_r.id;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_kind_r  <= KIND_NONE;
      act_id_r    <= '0;
      aud_cur_r   <= SLOT_EMPTY;
      aud_pend_r  <= SLOT_EMPTY;
      dsp_cur_r   <= SLOT_EMPTY;
      dsp_pend_r  <= SLOT_EMPTY;
      mb_aud_r    <= SLOT_EMPTY;
      mb_dsp_r    <= SLOT_EMPTY;
      dsp_phase_r <= PH_NOT_STARTED;
      mb_cnt_r    <= '0;
    end else if (push) begin
      act_kind_r  <= act_kind_nxt;
      act_id_r    <= act_id_nxt;
      aud_cur_r   <= aud_cur_nxt;
      aud_pend_r  <= aud_pend_nxt;
      dsp_cur_r   <= dsp_cur_nxt;
      dsp_pend_r  <= dsp_pend_nxt;
      mb_aud_r    <= mb_aud_nxt;
      mb_dsp_r    <= mb_dsp_nxt;
      dsp_phase_r <= dsp_phase_nxt;
      mb_cnt_r    <= mb_cnt_nxt;
    end
  end

  // Two-entry result buffer: output register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_main_v_r <= 1'b0;
      out_skid_v_r <= 1'b0;
    end else if (pop && out_skid_v_r) begin
      out_skid_v_r <= 1'b0;
    end else if (pop || !out_main_v_r) begin
      out_main_v_r <= push;
    end else if (push) begin
      out_skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && out_skid_v_r) begin
      out_main_r <= out_skid_r;
    end else if (pop || !out_main_v_r) begin
      out_main_r <= res;
    end else if (push) begin
      out_skid_r <= res;
    end
  end

  assign out_ch.valid                 = out_main_v_r;
  assign out_ch.action                = out_main_r.action;
  assign out_ch.action_task           = out_main_r.action_task;
  assign out_ch.audio_done            = out_main_r.audio_done;
  assign out_ch.display_done          = out_main_r.display_done;
  assign out_ch.done_task             = out_main_r.done_task;
  assign out_ch.start_display_request = out_main_r.start_display_request;
  assign out_ch.vblank_notify         = out_main_r.vblank_notify;
  assign out_ch.mailbox_dropped       = out_main_r.mailbox_dropped;

`ifndef NO_ASSERTIONS
  a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
    out_skid_v_r |-> out_main_v_r)
    else $error("skid entry holds an item while the output register is empty");

  a_phase_needs_task: assert property (@(posedge clk) disable iff (!rst_n)
    !dsp_cur_r.valid |-> dsp_phase_r == PH_NOT_STARTED)
    else $error("display phase advanced without a current display task");

  a_idle_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    act_kind_r == KIND_NONE |-> act_id_r == '0)
    else $error("active id kept while coprocessor idle");

  a_mailbox_bound: assert property (@(posedge clk) disable iff (!rst_n)
    mb_cnt_r <= MB_CNT_BITS'(MAILBOX_DEPTH))
    else $error("mailbox count exceeds depth");
`endif

endmodule

FILE: dv/tb_coprocessor_task_scheduler.sv
// Testbench for the coprocessor task scheduler: directed table, random events, scoreboard.
`timescale 1ns / 100ps

module tb_coprocessor_task_scheduler;
  import cts_pkg::*;

  localparam logic [OP_BITS-1:0]       OP_RSVD_6          = 3'd6;
  localparam logic [OP_BITS-1:0]       OP_RSVD_7          = 3'd7;
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_LISTENER_MASK = '0;
  localparam int N_DIR        = 26;
  localparam int PHASE_ITEMS  = 250;
  localparam int N_PHASES     = 5;
  localparam int SETTLE_LIMIT = 20000;

  localparam result_t NO_RESULT = '{ACT_NONE, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 2'b00, 1'b0};
  localparam result_t VBL_ONLY  = '{ACT_NONE, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 2'b11, 1'b0};
  localparam result_t DROPPED   = '{ACT_NONE, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 2'b00, 1'b1};

  typedef struct {
    logic [OP_BITS-1:0] op;
    task_id_t           id;
    logic               is_audio;
    logic               yielded;
    int                 reps;
    bit                 typed;
    result_t            res;
  } stim_row_t;

  // directed walk, listener mask set to all ones beforehand
  stim_row_t dir_rows [N_DIR] = '{
    '{OP_RSVD_6,     8'h00, 1'b0, 1'b0,  1, 1'b1, NO_RESULT},
    '{OP_RSVD_7,     8'hFF, 1'b1, 1'b1,  1, 1'b1, NO_RESULT},
    '{OP_COP_DONE,   8'h00, 1'b0, 1'b1,  1, 1'b1, NO_RESULT},   // nothing running
    '{OP_DSP_DONE,   8'h00, 1'b0, 1'b0,  1, 1'b1, NO_RESULT},   // no display task
    '{OP_START_DSP,  8'h00, 1'b0, 1'b0,  1, 1'b1, NO_RESULT},
    '{OP_VBLANK,     8'h00, 1'b0, 1'b0,  1, 1'b1, VBL_ONLY},
    '{OP_MB_SUBMIT,  8'hFF, 1'b1, 1'b0,  1, 1'b1, NO_RESULT},
    '{OP_MB_SUBMIT,  8'h00, 1'b0, 1'b0,  1, 1'b1, NO_RESULT},
    '{OP_VBLANK,     8'h00, 1'b0, 1'b0,  1, 1'b0, NO_RESULT},   // audio starts
    '{OP_VBLANK,     8'h00, 1'b0, 1'b0,  1, 1'b0, NO_RESULT},
    '{OP_COP_DONE,   8'h00, 1'b0, 1'b1,  1, 1'b0, NO_RESULT},   // audio done, display starts
    '{OP_MB_SUBMIT,  8'h5A, 1'b1, 1'b0,  1, 1'b0, NO_RESULT},
    '{OP_VBLANK,     8'h00, 1'b0, 1'b0,  1, 1'b0, NO_RESULT},   // display asked to yield
    '{OP_VBLANK,     8'h00, 1'b0, 1'b0,  1, 1'b0, NO_RESULT},   // yield asked again
    '{OP_COP_DONE,   8'h00, 1'b0, 1'b0,  1, 1'b0, NO_RESULT},   // did not yield: finished
    '{OP_COP_DONE,   8'h00, 1'b0, 1'b1,  1, 1'b0, NO_RESULT},
    '{OP_DSP_DONE,   8'h00, 1'b0, 1'b0,  1, 1'b0, NO_RESULT},
    '{OP_DSP_SUBMIT, 8'hA5, 1'b0, 1'b0,  1, 1'b0, NO_RESULT},
    '{OP_DSP_SUBMIT, 8'h3C, 1'b0, 1'b0,  1, 1'b0, NO_RESULT},
    '{OP_START_DSP,  8'h00, 1'b0, 1'b0,  1, 1'b0, NO_RESULT},
    '{OP_DSP_DONE,   8'h00, 1'b0, 1'b0,  1, 1'b0, NO_RESULT},   // done while still running
    '{OP_COP_DONE,   8'h00, 1'b0, 1'b0,  1, 1'b0, NO_RESULT},   // phase update without task
    '{OP_VBLANK,     8'h00, 1'b0, 1'b0,  1, 1'b0, NO_RESULT},
    '{OP_MB_SUBMIT,  8'h81, 1'b0, 1'b0, 16, 1'b0, NO_RESULT},   // fill the mailbox
    '{OP_MB_SUBMIT,  8'h7E, 1'b1, 1'b0,  1, 1'b1, DROPPED},
    '{OP_VBLANK,     8'h00, 1'b0, 1'b0,  1, 1'b0, NO_RESULT}
  };

  logic [1:0] phase_masks [N_PHASES] = '{2'd0, 2'd2, 2'd1, 2'd3, 2'd0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  cts_in_if  in_ch ();
  cts_out_if out_ch ();

  coprocessor_task_scheduler uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // scheduler shadow state
  kind_t       run_kind  = KIND_NONE;
  task_id_t    run_id    = '0;
  slot_t       aud_cur   = SLOT_EMPTY;
  slot_t       aud_nxt   = SLOT_EMPTY;
  slot_t       dsp_cur   = SLOT_EMPTY;
  slot_t       dsp_nxt   = SLOT_EMPTY;
  slot_t       mb_aud    = SLOT_EMPTY;
  slot_t       mb_dsp    = SLOT_EMPTY;
  phase_t      dsp_phase = PH_NOT_STARTED;
  int unsigned mb_count  = 0;
  logic [1:0]  listener_mask = 2'b00;
  result_t     sched_out;

  result_t pending_results [$];

  int err_count     = 0;
  int events_sent   = 0;
  int rsvd_sent     = 0;
  int results_seen  = 0;
  int yield_reqs    = 0;
  int audio_dones   = 0;
  int display_dones = 0;
  int drops         = 0;
  bit random_on     = 1'b0;
  bit hold_off      = 1'b0;

  function automatic void launch_audio();
    if (!aud_cur.valid) return;
    run_kind = KIND_AUDIO;
    run_id   = aud_cur.id;
    sched_out.action      = ACT_START_AUDIO;
    sched_out.action_task = run_id;
  endfunction

  function automatic void launch_display();
    if (!dsp_cur.valid) return;
    run_kind  = KIND_DSP;
    run_id    = dsp_cur.id;
    dsp_phase = PH_RUNNING;
    sched_out.action      = ACT_START_DSP;
    sched_out.action_task = run_id;
  endfunction

  function automatic result_t schedule_event(logic [OP_BITS-1:0] op, task_id_t id,
                                             logic is_audio, logic yielded);
    kind_t    was_kind;
    task_id_t was_id;
    sched_out = NO_RESULT;
    case (op)
      OP_MB_SUBMIT: begin
        if (mb_count >= MAILBOX_DEPTH) begin
          sched_out.mailbox_dropped = 1'b1;
        end else begin
          mb_count++;
          if (is_audio) mb_aud = '{valid: 1'b1, id: id};
          else mb_dsp = '{valid: 1'b1, id: id};
        end
      end
      OP_DSP_SUBMIT: begin
        if (!dsp_cur.valid) begin
          dsp_cur   = '{valid: 1'b1, id: id};
          dsp_phase = PH_NOT_STARTED;
          dsp_nxt   = SLOT_EMPTY;
          sched_out.start_display_request = 1'b1;
        end else begin
          dsp_nxt = '{valid: 1'b1, id: id};
        end
      end
      OP_VBLANK: begin
        // promote mailbox, then fill empty current slots
        if (mb_aud.valid) aud_nxt = mb_aud;
        if (mb_dsp.valid) dsp_nxt = mb_dsp;
        mb_aud   = SLOT_EMPTY;
        mb_dsp   = SLOT_EMPTY;
        mb_count = 0;
        if (!aud_cur.valid && aud_nxt.valid) begin
          aud_cur = aud_nxt;
          aud_nxt = SLOT_EMPTY;
        end
        if (!dsp_cur.valid && dsp_nxt.valid) begin
          dsp_cur   = dsp_nxt;
          dsp_nxt   = SLOT_EMPTY;
          dsp_phase = PH_NOT_STARTED;
        end
        if (aud_cur.valid) begin
          if (run_kind == KIND_NONE) begin
            launch_audio();
          end else if (run_kind == KIND_DSP || run_kind == KIND_DSP_YIELD) begin
            run_kind = KIND_DSP_YIELD;
            if (dsp_cur.valid) dsp_phase = PH_INTERRUPTED;
            sched_out.action      = ACT_YIELD;
            sched_out.action_task = run_id;
          end
        end else if (run_kind == KIND_NONE && dsp_cur.valid && dsp_phase != PH_FINISHED) begin
          launch_display();
        end
        sched_out.vblank_notify = listener_mask;
      end
      OP_COP_DONE: begin
        if (run_kind != KIND_NONE) begin
          was_kind = run_kind;
          was_id   = run_id;
          run_kind = KIND_NONE;
          run_id   = '0;
          case (was_kind)
            KIND_DSP_YIELD: begin
              if (!yielded && dsp_cur.valid) dsp_phase = PH_FINISHED;
              launch_audio();
            end
            KIND_AUDIO: begin
              if (dsp_cur.valid && dsp_phase != PH_FINISHED) launch_display();
              aud_cur = SLOT_EMPTY;
              sched_out.audio_done = 1'b1;
              sched_out.done_task  = was_id;
            end
            default: begin
              if (dsp_cur.valid) dsp_phase = PH_FINISHED;
            end
          endcase
        end
      end
      OP_DSP_DONE: begin
        if (dsp_cur.valid) begin
          sched_out.display_done = 1'b1;
          sched_out.done_task    = dsp_cur.id;
          dsp_cur   = SLOT_EMPTY;
          dsp_phase = PH_NOT_STARTED;
        end
      end
      OP_START_DSP: begin
        if (run_kind == KIND_NONE && dsp_cur.valid && dsp_phase == PH_NOT_STARTED)
          launch_display();
      end
      default: ;
    endcase
    return sched_out;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, fname, want, got);
    end
  endfunction

  // All driving tasks are entered and left at a falling edge.
  task automatic send_event(logic [OP_BITS-1:0] op, task_id_t id, logic is_audio,
                            logic yielded, bit no_gaps, bit typed, result_t typed_res);
    int      gap;
    result_t r;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.op            = op;
    in_ch.task_id       = id;
    in_ch.task_is_audio = is_audio;
    in_ch.yielded       = yielded;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    r = schedule_event(op, id, is_audio, yielded);
    pending_results.push_back(typed ? typed_res : r);
    events_sent++;
    if (op == OP_RSVD_6 || op == OP_RSVD_7) rsvd_sent++;
    if (r.action == ACT_YIELD) yield_reqs++;
    if (r.audio_done) audio_dones++;
    if (r.display_done) display_dones++;
    if (r.mailbox_dropped) drops++;
  endtask

  // drop valid and wait until every item has come back
  task automatic settle();
    int waited;
    waited = 0;
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0 && waited < SETTLE_LIMIT) begin
      @(negedge clk);
      waited++;
    end
  endtask

  task automatic cfg_write_mask(logic [1:0] m);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_LISTENER_MASK;
    pwdata  = CFG_DATA_BITS'(m);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    listener_mask = m;
    @(negedge clk);
    // read back, back to back with the write
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    check_field("listener mask readback", CFG_DATA_BITS'(m), prdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  initial begin
    logic [OP_BITS-1:0] op;
    int r;
    int counted;
    int burst_left;
    in_ch.valid         = 1'b0;
    in_ch.op            = OP_MB_SUBMIT;
    in_ch.task_id       = '0;
    in_ch.task_is_audio = 1'b0;
    in_ch.yielded       = 1'b0;
    burst_left = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    cfg_write_mask(2'b11);
    for (int i = 0; i < N_DIR; i++) begin
      for (int k = 0; k < dir_rows[i].reps; k++)
        send_event(dir_rows[i].op, dir_rows[i].id, dir_rows[i].is_audio, dir_rows[i].yielded,
                   1'b0, dir_rows[i].typed, dir_rows[i].res);
    end

    random_on = 1'b1;
    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      cfg_write_mask(phase_masks[p]);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (burst_left > 0) begin
          op = OP_MB_SUBMIT;
          burst_left--;
        end else if ($urandom_range(0, 49) == 0) begin
          // overrun the mailbox before the next vblank
          burst_left = $urandom_range(MAILBOX_DEPTH, MAILBOX_DEPTH + 4);
          op = OP_MB_SUBMIT;
        end else if (r < 2)  op = $urandom_range(0, 1) ? OP_RSVD_7 : OP_RSVD_6;
        else if (r < 22)     op = OP_MB_SUBMIT;
        else if (r < 32)     op = OP_DSP_SUBMIT;
        else if (r < 52)     op = OP_VBLANK;
        else if (r < 74)     op = OP_COP_DONE;
        else if (r < 87)     op = OP_DSP_DONE;
        else                 op = OP_START_DSP;
        send_event(op, task_id_t'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), (counted % 125) < 25, 1'b0, NO_RESULT);
        if (op != OP_RSVD_6 && op != OP_RSVD_7) counted++;
      end
    end

    settle();
    repeat (4) @(negedge clk);
    if (pending_results.size() != 0) begin
      err_count += pending_results.size();
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
    end
    $display("Ran %0d events (%0d reserved opcodes) across %0d listener masks; %0d results checked.",
             events_sent, rsvd_sent, N_PHASES + 1, results_seen);
    $display("Saw %0d yield requests, %0d audio and %0d display completions, %0d mailbox drops.",
             yield_reqs, audio_dones, display_dones, drops);
    if (err_count == 0) begin
      $display("tb_coprocessor_task_scheduler: clean");
    end else begin
      $display("tb_coprocessor_task_scheduler: errors");
    end
    $finish;
  end

  // result side: random stalls, calm windows, and the long hold-off
  initial begin
    int rx_cycle;
    int stall_left;
    rx_cycle   = 0;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (hold_off) begin
        out_ch.ready = 1'b0;
      end else if (stall_left > 0) begin
        out_ch.ready = 1'b0;
        stall_left--;
      end else begin
        out_ch.ready = 1'b1;
        if ((rx_cycle % 600) >= 150 && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // hold the receiver off long enough for the block to fill and stall its input
  initial begin
    wait (random_on);
    repeat (200) @(posedge clk);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: unexpected item, expected none, got action %0d task %0h",
                 $time, out_ch.action, out_ch.action_task);
      end else begin
        want = pending_results.pop_front();
        check_field("action", 32'(want.action), 32'(out_ch.action));
        check_field("action_task", 32'(want.action_task), 32'(out_ch.action_task));
        check_field("audio_done", 32'(want.audio_done), 32'(out_ch.audio_done));
        check_field("display_done", 32'(want.display_done), 32'(out_ch.display_done));
        check_field("done_task", 32'(want.done_task), 32'(out_ch.done_task));
        check_field("start_display_request", 32'(want.start_display_request),
                    32'(out_ch.start_display_request));
        check_field("vblank_notify", 32'(want.vblank_notify), 32'(out_ch.vblank_notify));
        check_field("mailbox_dropped", 32'(want.mailbox_dropped), 32'(out_ch.mailbox_dropped));
      end
    end
  end

  initial begin
    #6000000;
    $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
    $display("tb_coprocessor_task_scheduler: errors");
    $finish;
  end

endmodule

FILE: files.f
hdl/cts_pkg.sv
hdl/cts_in_if.sv
hdl/cts_out_if.sv
hdl/coprocessor_task_scheduler.sv
dv/tb_coprocessor_task_scheduler.sv
